// File: hw/rtl/cse_pkg.sv
// Shared types, character codes and the byte classifier of the byte escaper.
package cse_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] ASCII_BSLASH = 8'h5C;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_SPACE  = 8'h20;
	localparam logic [7:0] ASCII_TILDE  = 8'h7E;
	localparam logic [7:0] CTRL_BS      = 8'h08;
	localparam logic [7:0] CTRL_TAB     = 8'h09;
	localparam logic [7:0] CTRL_LF      = 8'h0A;
	localparam logic [7:0] CTRL_VT      = 8'h0B;
	localparam logic [7:0] CTRL_FF      = 8'h0C;
	localparam logic [7:0] CTRL_CR      = 8'h0D;
	localparam logic [7:0] LETTER_B     = 8'h62;
	localparam logic [7:0] LETTER_F     = 8'h66;
	localparam logic [7:0] LETTER_N     = 8'h6E;
	localparam logic [7:0] LETTER_R     = 8'h72;
	localparam logic [7:0] LETTER_T     = 8'h74;
	localparam logic [7:0] LETTER_V     = 8'h76;

	// Step index of a run: at most four characters per byte.
	localparam logic [1:0] STEP_FIRST  = 2'd0;
	localparam logic [1:0] STEP_LETTER = 2'd1;
	localparam logic [1:0] STEP_OCTAL  = 2'd3;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_LETTER,
		KIND_OCTAL
	} kind_t;

	// One classified request: kind, the byte (or escape letter) and the string end mark.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] chr;
		logic       last;
	} desc_t;

	function automatic desc_t classify(input logic [7:0] b, input logic last);
		desc_t d;
		d.last = last;
		d.kind = KIND_LETTER;
		d.chr  = b;
		case (b)
			ASCII_BSLASH: d.chr = ASCII_BSLASH;
			CTRL_BS:      d.chr = LETTER_B;
			CTRL_FF:      d.chr = LETTER_F;
			CTRL_LF:      d.chr = LETTER_N;
			CTRL_CR:      d.chr = LETTER_R;
			CTRL_TAB:     d.chr = LETTER_T;
			CTRL_VT:      d.chr = LETTER_V;
			default: begin
				if (b >= ASCII_SPACE && b <= ASCII_TILDE) begin
					d.kind = KIND_PLAIN;
				end else begin
					d.kind = KIND_OCTAL;
				end
			end
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/cse_front.sv
// Front stage: accept input requests, classify each byte and register the descriptor.
module cse_front import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output desc_t      push_desc,
	input  logic       q_full
);

	logic  valid_s1;
	desc_t desc_s1;

	assign in_ready  = !valid_s1 || !q_full;
	assign push      = valid_s1;
	assign push_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			desc_s1 <= classify(in_byte, in_last);
		end
	end

endmodule

// File: hw/rtl/cse_queue.sv
// Short descriptor queue between the classifier and the character sequencer.
module cse_queue import cse_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head_desc
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	desc_t          mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

// File: hw/rtl/cse_back.sv
// Back stage: walk the head descriptor into the output register, one character per cycle while not stalled.
module cse_back import cse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  desc_t      head_desc,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       string_last
);

	logic [1:0] step_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       string_last_q;
	logic       load;
	logic       final_step;
	logic [7:0] next_char;
	logic [2:0] digit;

	assign load = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		case (head_desc.kind)
			KIND_PLAIN:  final_step = (step_q == STEP_FIRST);
			KIND_LETTER: final_step = (step_q == STEP_LETTER);
			default:     final_step = (step_q == STEP_OCTAL);
		endcase
	end

	always_comb begin
		case (step_q)
			2'd1:    digit = {1'b0, head_desc.chr[7:6]};
			2'd2:    digit = head_desc.chr[5:3];
			default: digit = head_desc.chr[2:0];
		endcase
	end

	always_comb begin
		if (step_q == STEP_FIRST) begin
			next_char = (head_desc.kind == KIND_PLAIN) ? head_desc.chr : ASCII_BSLASH;
		end else if (head_desc.kind == KIND_LETTER) begin
			next_char = head_desc.chr;
		end else begin
			next_char = ASCII_ZERO + {5'd0, digit};
		end
	end

	assign pop = load && final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= final_step ? STEP_FIRST : step_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q    <= next_char;
			run_last_q    <= final_step;
			string_last_q <= final_step && head_desc.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign string_last = string_last_q;

	// The string end mark only ever rides on the last character of a run.
	a_string_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && string_last_q |-> run_last_q)
		else $error("string_last without run_last");

	// Mid-run, the head descriptor must still be in the queue.
	a_head_held_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != STEP_FIRST |-> head_valid)
		else $error("run in progress with empty queue");

	// A non-final load advances the step by exactly one.
	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		load && !final_step |=> step_q == $past(step_q) + 2'd1)
		else $error("step did not advance");

	// A plain byte never starts a multi-character run.
	a_plain_single: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head_desc.kind == KIND_PLAIN |-> step_q == STEP_FIRST)
		else $error("plain byte mid-run");

endmodule

// File: hw/rtl/c_style_byte_escaper_top.sv
// Top level of the C-style byte escaper: classifier, descriptor queue, character sequencer.
//
// Usage:
//   Input channel (in_valid/in_ready, in_byte, in_last) takes one raw byte per request;
//   in_last marks the final byte of a string. Output channel (out_valid/out_ready,
//   out_char, run_last, string_last) gives one escaped character per request.
//   Printable bytes (0x20..0x7E except backslash) give one character; backslash and
//   the control codes BS, TAB, LF, VT, FF, CR give a backslash and a letter; every
//   other byte gives a backslash and three octal digits, most significant first.
//   run_last marks the last character of each byte; string_last marks it as well
//   when that byte carried in_last.
// Timing:
//   The first character of a byte reaches the output once the byte has passed the
//   classifier register, then the queue, then the output register.
//   The sequencer emits one character per cycle while out_ready is high, so a stream of
//   printable bytes runs at one byte per cycle; a byte gives 1, 2 or 4 characters,
//   one after another from the single output character register.
//   The queue (QUEUE_DEPTH entries) lets the input keep accepting while a long
//   escape drains or while the receiver stalls; once it fills, in_ready drops.
// Reset:
//   arst_n clears the queue, the sequencer step and all valid flags at once; no
//   clearing pass is needed and a request may be offered right after reset.
module c_style_byte_escaper_top import cse_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       run_last,
	output logic       string_last
);

	// Front to queue.
	logic  push;
	desc_t push_desc;
	logic  q_full;

	// Queue to back.
	logic  head_valid;
	desc_t head_desc;
	logic  pop;

	// Classify each accepted byte; hold when the queue is full.
	cse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	// Decouple classification from character output.
	cse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// Advance through the head descriptor's characters; drop it after its last one.
	cse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_desc   (head_desc),
		.pop         (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.run_last    (run_last),
		.string_last (string_last)
	);

endmodule
